@@ sv/multiset_bag_table_core_assert.svh @@
// Assertion macros used by the bag table sequencer.
`ifndef MULTISET_BAG_TABLE_CORE_ASSERT_SVH
`define MULTISET_BAG_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off during rst.
`define MBT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bag table assertion failed");

// Next-cycle implication, checked on clk, off during rst.
`define MBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bag table assertion failed");

`endif

@@ sv/mbt_pkg.sv @@
// Shared types and codes for the bag table.
package mbt_pkg;

  localparam int DEF_CAPACITY_ITEMS = 32;
  localparam int DEF_ITEM_WIDTH     = 16;

  localparam int ACT_W   = 2;
  localparam int VALUE_W = 16;
  localparam int STAT_W  = 2;
  localparam int FIELD_W = 6;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COUNT  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] occurrences;
    logic [FIELD_W-1:0] size;
  } res_t;

endpackage

@@ sv/mbt_mem.sv @@
// Entry store: one write port, one registered read port.
module mbt_mem #(
  parameter int DEPTH = mbt_pkg::DEF_CAPACITY_ITEMS,
  parameter int WIDTH = mbt_pkg::DEF_ITEM_WIDTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  mbt_pkg::mem_ctl_t mem_ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);
  import mbt_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/mbt_ctrl.sv @@
// Sequencer: insert, scan for remove/count, move last entry into the hole.
`include "multiset_bag_table_core_assert.svh"

module mbt_ctrl #(
  parameter int CAPACITY_ITEMS = mbt_pkg::DEF_CAPACITY_ITEMS,
  parameter int ITEM_WIDTH     = mbt_pkg::DEF_ITEM_WIDTH,
  localparam int CNT_W = $clog2(CAPACITY_ITEMS + 1),
  localparam int IDX_W = (CAPACITY_ITEMS > 1) ? $clog2(CAPACITY_ITEMS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mbt_pkg::ACT_W-1:0]   action,
  input  logic [mbt_pkg::VALUE_W-1:0] value,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mbt_pkg::res_t               res,
  output mbt_pkg::mem_ctl_t           mem_ctl,
  output logic [IDX_W-1:0]            rd_addr,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [ITEM_WIDTH-1:0]       wr_data,
  input  logic [ITEM_WIDTH-1:0]       rd_data
);
  import mbt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_REPLY = 3'd4;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY_ITEMS);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  logic [2:0]            state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      hits;
  logic [CNT_W-1:0]      last;
  logic                  pend;
  logic [IDX_W-1:0]      pend_idx;
  logic [IDX_W-1:0]      slot;
  logic [ACT_W-1:0]      act;
  logic [ITEM_WIDTH-1:0] key;
  logic [STAT_W-1:0]     status;
  logic                  match;

  assign last      = count - ONE;
  assign match     = pend && (rd_data == key);
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_REPLY);

  always_comb begin
    res.status      = status;
    res.occurrences = FIELD_W'(hits);
    res.size        = FIELD_W'(count);
  end

  always_comb begin
    mem_ctl = '0;
    rd_addr = idx[IDX_W-1:0];
    wr_addr = count[IDX_W-1:0];
    wr_data = ITEM_WIDTH'(value);
    unique case (state)
      S_IDLE: begin
        // insert appends at slot count in the accept cycle
        mem_ctl.wr_en = in_valid && (action == ACT_INSERT) && (count != CAP_CNT);
      end
      S_SCAN: begin
        mem_ctl.rd_en = (idx != count);
      end
      S_LAST: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = last[IDX_W-1:0];
      end
      S_MOVE: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = slot;
        wr_data       = rd_data;
      end
      S_REPLY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act    <= action;
            key    <= ITEM_WIDTH'(value);
            hits   <= '0;
            idx    <= '0;
            status <= ST_DONE;
            state  <= S_REPLY;
            unique case (action) inside
              ACT_INSERT: begin
                if (count == CAP_CNT) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + ONE;
                end
              end
              ACT_REMOVE, ACT_COUNT: begin
                if (count == '0) begin
                  status <= (action == ACT_REMOVE) ? ST_MISSING : ST_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (idx != count) begin
            pend     <= 1'b1;
            pend_idx <= idx[IDX_W-1:0];
            idx      <= idx + ONE;
          end
          // compare works on the data read for the previous scan address
          if (match) begin
            if (act == ACT_REMOVE) begin
              slot  <= pend_idx;
              pend  <= 1'b0;
              state <= S_LAST;
            end else begin
              hits <= hits + ONE;
            end
          end else if (!pend && (idx == count)) begin
            status <= (act == ACT_REMOVE) ? ST_MISSING : ST_DONE;
            state  <= S_REPLY;
          end
        end
        S_LAST: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          count <= last;
          state <= S_REPLY;
        end
        S_REPLY: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MBT_ASSERT_IMPL(a_count_bound, 1'b1, count <= CAP_CNT)
  `MBT_ASSERT_IMPL(a_write_phase, mem_ctl.wr_en, (state == S_IDLE) || (state == S_MOVE))
  `MBT_ASSERT_IMPL(a_full_status, res_valid && (status == ST_FULL), count == CAP_CNT)
  `MBT_ASSERT_NEXT(a_reply_done, res_valid && res_ready, state == S_IDLE)
  `MBT_ASSERT_NEXT(a_move_shrinks, state == S_MOVE, count == $past(count) - ONE)

endmodule

@@ sv/multiset_bag_table_core.sv @@
// Top level of the bag table: sequencer, entry store and result register.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------
//  in      | in_valid / in_ready | action, value
//  out     | out_valid/out_ready | status, occurrences, size
//
// Insert, unused actions, remove/count on an empty bag: no scan, straight to the reply.
// Remove/count with entries held: the single read port scans one entry per cycle; a
// remove that finds its value then reads the last entry and moves it into the hole.
// The next request is taken once the result has entered the output register.
// rst (synchronous) empties the bag; the entry store needs no clearing.
// Requests are taken while a result waits in the output register; a later result waits.
module multiset_bag_table_core #(
  parameter int CAPACITY_ITEMS = mbt_pkg::DEF_CAPACITY_ITEMS,
  parameter int ITEM_WIDTH     = mbt_pkg::DEF_ITEM_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mbt_pkg::ACT_W-1:0]   action,
  input  logic [mbt_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mbt_pkg::STAT_W-1:0]  status,
  output logic [mbt_pkg::FIELD_W-1:0] occurrences,
  output logic [mbt_pkg::FIELD_W-1:0] size
);
  import mbt_pkg::*;

  localparam int IDX_W = (CAPACITY_ITEMS > 1) ? $clog2(CAPACITY_ITEMS) : 1;

  mem_ctl_t              mem_ctl;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic [ITEM_WIDTH-1:0] rd_data;
  res_t                  res;
  logic                  res_valid;
  logic                  res_ready;

  mbt_ctrl #(
    .CAPACITY_ITEMS (CAPACITY_ITEMS),
    .ITEM_WIDTH     (ITEM_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data)
  );

  mbt_mem #(
    .DEPTH (CAPACITY_ITEMS),
    .WIDTH (ITEM_WIDTH)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      occurrences <= res.occurrences;
      size        <= res.size;
    end
  end

endmodule
